// ----- rtl/core/sat_pkg.sv -----
`default_nettype none
package sat_pkg;
    localparam int HistDepth = 10;
    localparam int MinFactor = 1229;
    localparam int SignChangeLimit = 4;
    localparam int QueueDepth = 2;

    typedef enum logic [2:0] {
        REG_GAIN = 3'd0, REG_DEADBAND = 3'd1, REG_CENTER = 3'd2, REG_MAX_ASSIST = 3'd3,
        REG_MAX_STEP = 3'd4, REG_OSC_AMP = 3'd5, REG_LOW_SPEED = 3'd6, REG_HIGH_SPEED = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [9:0]  gain;
        logic [9:0]  deadband;
        logic [11:0] center_limit;
        logic [12:0] max_assist;
        logic [12:0] max_step;
        logic [12:0] osc_amp;
        logic [11:0] low_speed;
        logic [11:0] high_speed;
    } t_cfg;

    // classified sample handed from front to back
    typedef struct packed {
        logic signed [13:0] torque;
        logic [11:0]        speed;
        logic signed [15:0] angle;
        logic signed [14:0] rate;
        logic               base_on;
        logic               center_on;
        logic               speed_low;
        logic               speed_high;
    } t_item;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DIV, ST_FACTOR, ST_MUL1, ST_MUL2, ST_CDIV, ST_DDIV, ST_SUM,
        ST_SCAN, ST_STEP, ST_OUT
    } t_state;
endpackage
`default_nettype wire

// ----- rtl/core/steering_assist_torque_limiter.sv -----
`default_nettype none
// Each word runs a 26-step divide for the speed factor (none when the speed
// is at or below low_speed or at or above high_speed), then the scan reads
// one history entry per cycle. Words are processed one at a time; a 2-deep
// queue takes words early.
// Reset (synchronous, active low): registers to defaults, history,
// pointer and previous output to zero, queue and result empty.
module steering_assist_torque_limiter #(
    parameter int HIST_DEPTH = sat_pkg::HistDepth
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [2:0]        i_cfg_idx,
    input  wire logic [12:0]       i_cfg_data,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic signed [13:0] i_driver_torque,
    input  wire logic [11:0]       i_vehicle_speed,
    input  wire logic signed [15:0] i_wheel_angle,
    input  wire logic signed [14:0] i_angular_rate,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic signed [13:0]     o_total_assist,
    output logic signed [15:0]     o_base_assist,
    output logic signed [15:0]     o_center_torque,
    output logic signed [15:0]     o_damping_torque,
    output logic [12:0]            o_speed_factor,
    output logic                   o_clamped,
    output logic                   o_oscillating,
    output logic                   o_step_limited
);
    sat_pkg::t_cfg r_cfg;
    sat_pkg::t_item w_item;
    logic w_qv, w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain <= 10'd384; r_cfg.deadband <= 10'd26; r_cfg.center_limit <= 12'd256;
            r_cfg.max_assist <= 13'd2048; r_cfg.max_step <= 13'd2560;
            r_cfg.osc_amp <= 13'd512; r_cfg.low_speed <= 12'd160;
            r_cfg.high_speed <= 12'd1600;
        end else if (i_cfg_we) begin
            case (sat_pkg::t_reg_idx'(i_cfg_idx))
                sat_pkg::REG_GAIN:       r_cfg.gain <= i_cfg_data[9:0];
                sat_pkg::REG_DEADBAND:   r_cfg.deadband <= i_cfg_data[9:0];
                sat_pkg::REG_CENTER:     r_cfg.center_limit <= i_cfg_data[11:0];
                sat_pkg::REG_MAX_ASSIST: r_cfg.max_assist <= i_cfg_data;
                sat_pkg::REG_MAX_STEP:   r_cfg.max_step <= i_cfg_data;
                sat_pkg::REG_OSC_AMP:    r_cfg.osc_amp <= i_cfg_data;
                sat_pkg::REG_LOW_SPEED:  r_cfg.low_speed <= i_cfg_data[11:0];
                sat_pkg::REG_HIGH_SPEED: r_cfg.high_speed <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    sat_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready,
        .i_driver_torque, .i_vehicle_speed, .i_wheel_angle, .i_angular_rate,
        .i_cfg(r_cfg), .o_q_valid(w_qv), .i_q_pop(w_pop), .o_q_item(w_item)
    );

    sat_back #(.HIST_DEPTH(HIST_DEPTH)) u_back (
        .i_clk, .i_rst_n, .i_cfg(r_cfg),
        .i_q_valid(w_qv), .o_q_pop(w_pop), .i_q_item(w_item),
        .o_valid, .i_ready, .o_total_assist, .o_base_assist, .o_center_torque,
        .o_damping_torque, .o_speed_factor, .o_clamped, .o_oscillating, .o_step_limited
    );
endmodule
`default_nettype wire

// ----- rtl/core/sat_front.sv -----
`default_nettype none
module sat_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic signed [13:0] i_driver_torque,
    input  wire logic [11:0]       i_vehicle_speed,
    input  wire logic signed [15:0] i_wheel_angle,
    input  wire logic signed [14:0] i_angular_rate,
    input  wire sat_pkg::t_cfg     i_cfg,
    output logic                   o_q_valid,
    input  wire logic              i_q_pop,
    output sat_pkg::t_item         o_q_item
);
    sat_pkg::t_item r_q [sat_pkg::QueueDepth];
    logic [1:0] r_cnt;
    logic r_wp, r_rp;
    logic [13:0] w_at;
    sat_pkg::t_item w_item;
    logic w_push;

    assign w_at = i_driver_torque[13] ? 14'(-i_driver_torque) : 14'(i_driver_torque);
    always_comb begin
        w_item.torque     = i_driver_torque;
        w_item.speed      = i_vehicle_speed;
        w_item.angle      = i_wheel_angle;
        w_item.rate       = i_angular_rate;
        // |-8192| wraps to 8192 in 14 bits unsigned; fine as unsigned
        w_item.base_on    = w_at > 14'(i_cfg.deadband);
        w_item.center_on  = w_at < 14'(i_cfg.center_limit);
        w_item.speed_low  = i_vehicle_speed <= i_cfg.low_speed;
        w_item.speed_high = i_vehicle_speed >= i_cfg.high_speed;
    end

    assign o_ready   = r_cnt != 2'd2;
    assign w_push    = i_valid && o_ready;
    assign o_q_valid = r_cnt != 2'd0;
    assign o_q_item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_item;
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (i_q_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_q_pop);
        end
    end
endmodule
`default_nettype wire

// ----- rtl/core/sat_back.sv -----
`default_nettype none
module sat_back #(
    parameter int HIST_DEPTH = sat_pkg::HistDepth
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire sat_pkg::t_cfg  i_cfg,
    input  wire logic           i_q_valid,
    output logic                o_q_pop,
    input  wire sat_pkg::t_item i_q_item,
    output logic                o_valid,
    input  wire logic           i_ready,
    output logic signed [13:0]  o_total_assist,
    output logic signed [15:0]  o_base_assist,
    output logic signed [15:0]  o_center_torque,
    output logic signed [15:0]  o_damping_torque,
    output logic [12:0]         o_speed_factor,
    output logic                o_clamped,
    output logic                o_oscillating,
    output logic                o_step_limited
);
    localparam int PW = $clog2(HIST_DEPTH);
    // ceil(2^35 / 625) and ceil(2^33 / 125): exact floor divides over the
    // magnitudes seen here (/5000 = >>3 then /625, /250 = >>1 then /125)
    localparam logic [25:0] CenterRecip = 26'd54975582;
    localparam logic [26:0] DampRecip   = 27'd68719477;

    sat_pkg::t_state r_st, n_st;
    sat_pkg::t_item r_it;
    // restoring divider for the speed factor: r_num / r_den, 26-bit dividend
    logic [25:0] r_num, r_quo;
    logic [25:0] r_rem;
    logic [12:0] r_den;
    logic [4:0]  r_dcnt;
    logic        r_neg;
    logic [27:0] r_mag;
    logic [12:0] r_sf;
    logic signed [37:0] r_prod;
    logic signed [15:0] r_base, r_center, r_damp;
    logic signed [13:0] r_total, r_prev, r_outv;
    logic r_clamp, r_osc, r_stepl;
    logic signed [13:0] r_hist [HIST_DEPTH];
    logic [PW-1:0] r_ptr, r_sidx;
    logic [5:0] r_scnt;
    logic [5:0] r_changes;
    logic [13:0] r_peak;
    logic signed [13:0] r_sprev;
    logic r_out_v;

    logic [26:0] w_trial;
    logic w_div_done;
    assign w_trial    = {r_rem, r_num[25]} - {14'd0, r_den};
    assign w_div_done = r_dcnt == 5'd0;

    function automatic logic signed [15:0] sat16(input logic signed [26:0] v);
        if (v > 27'sd32767) return 16'sd32767;
        if (v < -27'sd32768) return -16'sd32768;
        return v[15:0];
    endfunction

    logic signed [29:0] w_c, w_d;
    assign w_c = -(30'(r_it.angle) * $signed({17'd0, 13'd1600 + {1'b0, r_it.speed}}));
    assign w_d = -(30'(r_it.rate) * $signed({17'd0, 13'd800 + {1'b0, r_it.speed}}));

    logic [50:0] w_cprod;
    logic [53:0] w_dprod;
    logic signed [26:0] w_cval, w_dval;
    assign w_cprod = {26'd0, r_mag[27:3]} * {25'd0, CenterRecip};
    assign w_dprod = {27'd0, r_mag[27:1]} * {27'd0, DampRecip};
    assign w_cval  = r_neg ? -$signed({11'd0, w_cprod[50:35]})
                           : $signed({11'd0, w_cprod[50:35]});
    assign w_dval  = r_neg ? -$signed({6'd0, w_dprod[53:33]})
                           : $signed({6'd0, w_dprod[53:33]});

    always_comb begin
        n_st = r_st;
        case (r_st)
            sat_pkg::ST_IDLE:   if (i_q_valid && !r_out_v) n_st = sat_pkg::ST_DIV;
            sat_pkg::ST_DIV:    n_st = sat_pkg::ST_FACTOR;
            sat_pkg::ST_FACTOR: if (w_div_done) n_st = sat_pkg::ST_MUL1;
            sat_pkg::ST_MUL1:   n_st = sat_pkg::ST_MUL2;
            sat_pkg::ST_MUL2:   n_st = sat_pkg::ST_CDIV;
            sat_pkg::ST_CDIV:   n_st = sat_pkg::ST_DDIV;
            sat_pkg::ST_DDIV:   n_st = sat_pkg::ST_SUM;
            sat_pkg::ST_SUM:    n_st = sat_pkg::ST_SCAN;
            sat_pkg::ST_SCAN:   if (r_scnt == 6'(HIST_DEPTH)) n_st = sat_pkg::ST_STEP;
            sat_pkg::ST_STEP:   n_st = sat_pkg::ST_OUT;
            sat_pkg::ST_OUT:    n_st = sat_pkg::ST_IDLE;
            default:            n_st = sat_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop = (r_st == sat_pkg::ST_IDLE) && i_q_valid && !r_out_v;
    end

    logic signed [18:0] w_sum;
    logic [18:0] w_asum;
    logic signed [14:0] w_diff;
    logic [14:0] w_adiff;
    logic signed [13:0] w_x;
    logic [13:0] w_ax;
    assign w_sum  = 19'(r_base) + 19'(r_center) + 19'(r_damp);
    assign w_asum = w_sum[18] ? 19'(-w_sum) : 19'(w_sum);
    assign w_diff = 15'(r_total) - 15'(r_prev);
    assign w_adiff = w_diff[14] ? 15'(-w_diff) : 15'(w_diff);
    assign w_x  = r_hist[r_sidx];
    assign w_ax = w_x[13] ? 14'(-w_x) : 14'(w_x);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= sat_pkg::ST_IDLE;
            r_out_v <= 1'b0;
            r_ptr   <= '0;
            r_prev  <= '0;
            r_dcnt  <= '0;
            for (int i = 0; i < HIST_DEPTH; i++) r_hist[i] <= '0;
        end else begin
            r_st <= n_st;
            if (r_out_v && i_ready) r_out_v <= 1'b0;
            if (r_dcnt != 5'd0) begin
                r_num  <= {r_num[24:0], 1'b0};
                r_dcnt <= r_dcnt - 5'd1;
                if (!w_trial[26]) begin
                    r_rem <= w_trial[25:0];
                    r_quo <= {r_quo[24:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[24:0], r_num[25]};
                    r_quo <= {r_quo[24:0], 1'b0};
                end
            end
            case (r_st)
                sat_pkg::ST_IDLE: if (o_q_pop) r_it <= i_q_item;
                sat_pkg::ST_DIV: begin
                    r_clamp <= 1'b0; r_osc <= 1'b0; r_stepl <= 1'b0;
                    // (v-low)*2867/(high-low)
                    r_num <= {14'd0, r_it.speed - i_cfg.low_speed} * 26'd2867;
                    r_den <= {1'b0, i_cfg.high_speed - i_cfg.low_speed};
                    r_rem <= '0; r_quo <= '0;
                    r_dcnt <= (r_it.speed_low || r_it.speed_high) ? 5'd0 : 5'd26;
                end
                sat_pkg::ST_FACTOR: if (w_div_done) begin
                    if (r_it.speed_low) r_sf <= 13'd4096;
                    else if (r_it.speed_high) r_sf <= 13'(sat_pkg::MinFactor);
                    else r_sf <= 13'd4096 - r_quo[12:0];
                    r_prod <= 38'(r_it.torque) * 38'($signed({1'b0, i_cfg.gain}));
                end
                sat_pkg::ST_MUL1: begin
                    r_prod <= r_prod * 38'($signed({1'b0, r_sf}));
                end
                sat_pkg::ST_MUL2: begin
                    // rounded shift by 20, half away from zero
                    if (!r_it.base_on) r_base <= '0;
                    else if (r_prod < 0)
                        r_base <= sat16(27'(-((-r_prod + 38'sd524288) >>> 20)));
                    else r_base <= sat16(27'((r_prod + 38'sd524288) >>> 20));
                    r_neg <= w_c < 0;
                    r_mag <= 28'(w_c < 0 ? -w_c : w_c) + 28'd2500;
                end
                sat_pkg::ST_CDIV: begin
                    r_center <= r_it.center_on ? sat16(w_cval) : '0;
                    r_neg <= w_d < 0;
                    r_mag <= 28'(w_d < 0 ? -w_d : w_d) + 28'd125;
                end
                sat_pkg::ST_DDIV: r_damp <= sat16(w_dval);
                sat_pkg::ST_SUM: begin
                    if (w_asum > 19'(i_cfg.max_assist)) begin
                        r_clamp <= 1'b1;
                        r_hist[r_ptr] <= w_sum[18] ? -$signed({1'b0, i_cfg.max_assist})
                                                   : $signed({1'b0, i_cfg.max_assist});
                        r_total <= w_sum[18] ? -$signed({1'b0, i_cfg.max_assist})
                                             : $signed({1'b0, i_cfg.max_assist});
                    end else begin
                        r_hist[r_ptr] <= w_sum[13:0];
                        r_total <= w_sum[13:0];
                    end
                    r_sidx <= (r_ptr == PW'(HIST_DEPTH - 1)) ? '0 : r_ptr + PW'(1);
                    r_ptr  <= (r_ptr == PW'(HIST_DEPTH - 1)) ? '0 : r_ptr + PW'(1);
                    r_scnt <= '0; r_changes <= '0; r_peak <= '0; r_sprev <= '0;
                end
                sat_pkg::ST_SCAN: if (r_scnt != 6'(HIST_DEPTH)) begin
                    if ((r_sprev > 0 && w_x < 0) || (r_sprev < 0 && w_x > 0))
                        r_changes <= r_changes + 6'd1;
                    if (w_ax > r_peak) r_peak <= w_ax;
                    r_sprev <= w_x;
                    r_sidx <= (r_sidx == PW'(HIST_DEPTH - 1)) ? '0 : r_sidx + PW'(1);
                    r_scnt <= r_scnt + 6'd1;
                end else if (r_changes > 6'(sat_pkg::SignChangeLimit)
                             && r_peak > 14'(i_cfg.osc_amp)) begin
                    r_osc <= 1'b1;
                    r_total <= '0;
                end
                sat_pkg::ST_STEP: begin
                    if (w_adiff > 15'(i_cfg.max_step)) begin
                        r_stepl <= 1'b1;
                        r_outv <= 14'(w_diff[14] ? 15'(r_prev) - 15'(i_cfg.max_step)
                                                 : 15'(r_prev) + 15'(i_cfg.max_step));
                    end else r_outv <= r_total;
                end
                sat_pkg::ST_OUT: begin
                    r_prev  <= r_outv;
                    r_out_v <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign o_valid          = r_out_v;
    assign o_total_assist   = r_prev;
    assign o_base_assist    = r_base;
    assign o_center_torque  = r_center;
    assign o_damping_torque = r_damp;
    assign o_speed_factor   = r_sf;
    assign o_clamped        = r_clamp;
    assign o_oscillating    = r_osc;
    assign o_step_limited   = r_stepl;
endmodule
`default_nettype wire
